[design/ptpd_pkg.sv]
// Shared constants, types and the arctangent table for the phase derotator.
package ptpd_pkg;

  // Default field widths
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int PHASE_WIDTH_DEF  = 16;

  // Vector guard bits and CORDIC depth
  localparam int GUARD_BITS   = 8;
  localparam int CORDIC_STEPS = 24;
  localparam int ANGLE_WIDTH  = 32;

  // Inverse CORDIC gain, Q24
  localparam logic [23:0] INV_GAIN_Q24 = 24'd10188014;

  // Run counter limits and register reset values
  localparam logic [7:0] RUN_MAX        = 8'd255;
  localparam logic [7:0] PLATEAU_RESET  = 8'd20;

  // Configuration register indexes
  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_PLATEAU   = 1'b1;

  // Control that travels along the cell row with each word
  typedef struct packed {
    logic valid;
    logic vec;   // 1: vectoring (measure angle), 0: rotation
  } ptpd_ctl_t;

  // atan(2^-k) on a 32-bit turn scale
  function automatic logic [ANGLE_WIDTH-1:0] atan_turn(input int k);
    logic [ANGLE_WIDTH-1:0] v;
    case (k)
      0:       v = 32'h20000000;
      1:       v = 32'h12E4051D;
      2:       v = 32'h09FB385B;
      3:       v = 32'h051111D4;
      4:       v = 32'h028B0D43;
      5:       v = 32'h0145D7E1;
      6:       v = 32'h00A2F61E;
      7:       v = 32'h00517C55;
      8:       v = 32'h0028BE53;
      9:       v = 32'h00145F2F;
      10:      v = 32'h000A2F98;
      11:      v = 32'h000517CC;
      12:      v = 32'h00028BE6;
      13:      v = 32'h000145F3;
      14:      v = 32'h0000A2FA;
      15:      v = 32'h0000517D;
      16:      v = 32'h000028BE;
      17:      v = 32'h0000145F;
      18:      v = 32'h00000A30;
      19:      v = 32'h00000518;
      20:      v = 32'h0000028C;
      21:      v = 32'h00000146;
      22:      v = 32'h000000A3;
      23:      v = 32'h00000051;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[design/ptpd_cell.sv]
// One CORDIC micro-rotation cell; a row of these forms the angle/rotation chain.
module ptpd_cell
  import ptpd_pkg::*;
#(
  parameter int STEP = 0,
  parameter int VW   = 27
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  ptpd_ctl_t               ctl_in,
  input  logic signed [VW-1:0]    x_in,
  input  logic signed [VW-1:0]    y_in,
  input  logic signed [ANGLE_WIDTH:0] z_in,
  output ptpd_ctl_t               ctl_out,
  output logic signed [VW-1:0]    x_out,
  output logic signed [VW-1:0]    y_out,
  output logic signed [ANGLE_WIDTH:0] z_out
);

  localparam logic [ANGLE_WIDTH:0] ATAN = {1'b0, atan_turn(STEP)};

  ptpd_ctl_t                   ctl_r;
  logic signed [VW-1:0]        x_r, y_r, x_nxt, y_nxt;
  logic signed [ANGLE_WIDTH:0] z_r, z_nxt;
  logic signed [VW-1:0]        xs, ys;
  logic                        neg_turn;

  // Pick direction: vectoring drives y to zero, rotation drives z to zero
  always_comb begin
    xs       = x_in >>> STEP;
    ys       = y_in >>> STEP;
    neg_turn = ctl_in.vec ? ~y_in[VW-1] : z_in[ANGLE_WIDTH];
    if (neg_turn) begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + $signed(ATAN);
    end else begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - $signed(ATAN);
    end
  end

  // Advance control to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_in;
    end
  end

  // Hand the vector and angle to the neighbor
  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    z_r <= z_nxt;
  end

  assign ctl_out = ctl_r;
  assign x_out   = x_r;
  assign y_out   = y_r;
  assign z_out   = z_r;

endmodule

[design/ptpd_finish.sv]
// Output scaling: round off guard bits, apply inverse CORDIC gain, saturate.
module ptpd_finish
  import ptpd_pkg::*;
#(
  parameter int SW = SAMPLE_WIDTH_DEF,
  parameter int VW = SAMPLE_WIDTH_DEF + GUARD_BITS + 3
) (
  input  logic                 clk,
  input  logic                 round_en,
  input  logic                 mul_en,
  input  logic signed [VW-1:0] x_in,
  input  logic signed [VW-1:0] y_in,
  output logic signed [SW-1:0] sat_i,
  output logic signed [SW-1:0] sat_q
);

  localparam int RW = VW - GUARD_BITS;
  localparam int MW = RW + 25;
  localparam logic [VW-1:0] RND_G = VW'(1) << (GUARD_BITS - 1);
  localparam logic [MW-1:0] RND_M = MW'(1) << 23;
  localparam logic signed [SW-1:0] MAXV = {1'b0, {(SW-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = {1'b1, {(SW-1){1'b0}}};

  logic signed [VW-1:0] sum_i, sum_q;
  logic signed [RW-1:0] rnd_i_r, rnd_q_r;
  logic signed [MW-1:0] prod_i_r, prod_q_r;
  logic signed [MW-1:0] acc_i, acc_q;
  logic signed [RW:0]   res_i, res_q;
  logic signed [24:0]   gain;

  assign gain  = $signed({1'b0, INV_GAIN_Q24});
  assign sum_i = x_in + $signed(RND_G);
  assign sum_q = y_in + $signed(RND_G);

  // Drop guard bits, rounding half up
  always_ff @(posedge clk) begin
    if (round_en) begin
      rnd_i_r <= sum_i[VW-1:GUARD_BITS];
      rnd_q_r <= sum_q[VW-1:GUARD_BITS];
    end
  end

  // Gain compensation product
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_i_r <= MW'(rnd_i_r * gain);
      prod_q_r <= MW'(rnd_q_r * gain);
    end
  end

  // Round the product and clamp to sample width
  always_comb begin
    acc_i = prod_i_r + $signed(RND_M);
    acc_q = prod_q_r + $signed(RND_M);
    res_i = acc_i[MW-1:24];
    res_q = acc_q[MW-1:24];
    if ((&res_i[RW:SW-1]) || !(|res_i[RW:SW-1])) begin
      sat_i = res_i[SW-1:0];
    end else begin
      sat_i = res_i[RW] ? MINV : MAXV;
    end
    if ((&res_q[RW:SW-1]) || !(|res_q[RW:SW-1])) begin
      sat_q = res_q[SW-1:0];
    end else begin
      sat_q = res_q[RW] ? MINV : MAXV;
    end
  end

endmodule

[design/plateau_triggered_phase_derotator.sv]
// Top level: plateau detection, phase latch and derotation through a CORDIC cell row.
//
//   channel | ports                                   | direction
//   input   | in_valid, in_stall, in_sig_*, in_corr_*  | sample + correlation word in
//   result  | out_valid, out_stall, out_i, out_q       | derotated sample word out
//   config  | cfg_we, cfg_idx, cfg_wdata               | register write
//
// One word is in flight at a time. A word that does not latch a new phase makes
// one pass through the 24-cell CORDIC row between accept and the next accept,
// with launch, rounding, gain multiply and output load. A word that latches the
// phase first makes a vectoring pass through the same row.
// Reset (synchronous, rst_n low) clears the run counter and phase and loads the
// register defaults.
// A full output register with out_stall high holds the finished word in the
// scaling stage; the input side stays stalled until it moves.
module plateau_triggered_phase_derotator
  import ptpd_pkg::*;
#(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
  parameter int PHASE_WIDTH  = PHASE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sig_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sig_q,
  input  logic signed [SAMPLE_WIDTH-1:0] in_corr_i,
  input  logic signed [SAMPLE_WIDTH-1:0] in_corr_q,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_i,
  output logic signed [SAMPLE_WIDTH-1:0] out_q,
  input  logic                          cfg_we,
  input  logic                          cfg_idx,
  input  logic [SAMPLE_WIDTH-1:0]       cfg_wdata
);

  localparam int VW = SAMPLE_WIDTH + GUARD_BITS + 3;
  localparam int ZW = ANGLE_WIDTH + 1;
  localparam logic [ZW-1:0] PH_RND = (ZW'(1) << (ANGLE_WIDTH - PHASE_WIDTH)) >> 1;
  localparam logic [SAMPLE_WIDTH-1:0] THR_RESET = SAMPLE_WIDTH'(1) << (SAMPLE_WIDTH - 2);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_VEC   = 3'd1;
  localparam logic [2:0] S_ROTGO = 3'd2;
  localparam logic [2:0] S_ROT   = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_SAT   = 3'd5;

  logic [2:0]                    state_r, state_nxt;
  logic signed [SAMPLE_WIDTH-1:0] thr_r;
  logic [7:0]                    plateau_r;
  logic [7:0]                    run_r, run_nxt;
  logic [PHASE_WIDTH-1:0]        phase_r, phase_nxt;
  logic signed [SAMPLE_WIDTH-1:0] sig_i_r, sig_q_r;
  logic                          out_valid_r;
  logic signed [SAMPLE_WIDTH-1:0] out_i_r, out_q_r;

  logic                          accept, hit, latch, corr_zero, out_free;
  logic [7:0]                    run_inc;

  // Cell row taps
  ptpd_ctl_t                     ctl_c [0:CORDIC_STEPS];
  logic signed [VW-1:0]          x_c   [0:CORDIC_STEPS];
  logic signed [VW-1:0]          y_c   [0:CORDIC_STEPS];
  logic signed [ZW-1:0]          z_c   [0:CORDIC_STEPS];

  // Head of the row
  ptpd_ctl_t                     ctl_h;
  logic signed [VW-1:0]          x_h, y_h;
  logic signed [ZW-1:0]          z_h;

  logic signed [VW-1:0]          cx, cy, rx, ry;
  logic [ANGLE_WIDTH-1:0]        rot_a, rot_a2;
  logic [ZW-1:0]                 ph_sum;
  logic signed [SAMPLE_WIDTH-1:0] sat_i, sat_q;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Plateau run tracking for the arriving word
  always_comb begin
    hit       = (in_corr_i >= thr_r);
    run_inc   = run_r + 8'd1;
    corr_zero = (in_corr_i == '0) && (in_corr_q == '0);
    latch     = 1'b0;
    run_nxt   = run_r;
    if (hit) begin
      if (run_r != RUN_MAX) begin
        run_nxt = run_inc;
        latch   = (run_inc == plateau_r);
      end
    end else begin
      run_nxt = '0;
    end
  end

  // Vectoring launch: fold the left half plane onto the right
  always_comb begin
    cx = VW'(in_corr_i) <<< GUARD_BITS;
    cy = VW'(in_corr_q) <<< GUARD_BITS;
    if (in_corr_i[SAMPLE_WIDTH-1]) begin
      cx = -cx;
      cy = -cy;
    end
  end

  // Rotation launch: angle is minus the stored phase, folded into +-quarter turn
  always_comb begin
    rot_a  = ANGLE_WIDTH'(0) - (ANGLE_WIDTH'(phase_r) << (ANGLE_WIDTH - PHASE_WIDTH));
    rot_a2 = rot_a;
    rx     = VW'(sig_i_r) <<< GUARD_BITS;
    ry     = VW'(sig_q_r) <<< GUARD_BITS;
    if (rot_a[ANGLE_WIDTH-1] != rot_a[ANGLE_WIDTH-2]) begin
      rx     = -rx;
      ry     = -ry;
      rot_a2 = rot_a + {1'b1, {(ANGLE_WIDTH-1){1'b0}}};
    end
  end

  // Feed the head of the row
  always_comb begin
    ctl_h = '0;
    x_h   = rx;
    y_h   = ry;
    z_h   = {rot_a2[ANGLE_WIDTH-1], rot_a2};
    if (state_r == S_ROTGO) begin
      ctl_h.valid = 1'b1;
    end else if (accept && latch && !corr_zero) begin
      ctl_h.valid = 1'b1;
      ctl_h.vec   = 1'b1;
      x_h         = cx;
      y_h         = cy;
      z_h         = in_corr_i[SAMPLE_WIDTH-1] ? ZW'(33'h080000000) : '0;
    end
  end

  assign ctl_c[0] = ctl_h;
  assign x_c[0]   = x_h;
  assign y_c[0]   = y_h;
  assign z_c[0]   = z_h;

  // Row of CORDIC cells
  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cell
    ptpd_cell #(
      .STEP (k),
      .VW   (VW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_in  (ctl_c[k]),
      .x_in    (x_c[k]),
      .y_in    (y_c[k]),
      .z_in    (z_c[k]),
      .ctl_out (ctl_c[k+1]),
      .x_out   (x_c[k+1]),
      .y_out   (y_c[k+1]),
      .z_out   (z_c[k+1])
    );
  end

  // Measured angle rounded half up to the phase width
  assign ph_sum = {1'b0, z_c[CORDIC_STEPS][ANGLE_WIDTH-1:0]} + PH_RND;

  // Gain compensation and saturation
  ptpd_finish #(
    .SW (SAMPLE_WIDTH),
    .VW (VW)
  ) u_finish (
    .clk      (clk),
    .round_en (state_r == S_ROT),
    .mul_en   (state_r == S_MUL),
    .x_in     (x_c[CORDIC_STEPS]),
    .y_in     (y_c[CORDIC_STEPS]),
    .sat_i    (sat_i),
    .sat_q    (sat_q)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (latch && !corr_zero) begin
            state_nxt = S_VEC;
          end else begin
            if (latch) begin
              phase_nxt = '0;
            end
            state_nxt = S_ROTGO;
          end
        end
      end
      S_VEC: begin
        if (ctl_c[CORDIC_STEPS].valid) begin
          phase_nxt = ph_sum[ANGLE_WIDTH-1 -: PHASE_WIDTH];
          state_nxt = S_ROTGO;
        end
      end
      S_ROTGO: state_nxt = S_ROT;
      S_ROT: begin
        if (ctl_c[CORDIC_STEPS].valid) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: state_nxt = S_SAT;
      S_SAT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state, run counter, phase and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      run_r       <= '0;
      phase_r     <= '0;
      thr_r       <= THR_RESET;
      plateau_r   <= PLATEAU_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      if (accept) begin
        run_r <= run_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_THRESHOLD: thr_r     <= cfg_wdata;
          CFG_PLATEAU:   plateau_r <= cfg_wdata[7:0];
          default:       ;
        endcase
      end
      if (state_r == S_SAT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the sample while its phase is worked out
  always_ff @(posedge clk) begin
    if (accept) begin
      sig_i_r <= in_sig_i;
      sig_q_r <= in_sig_q;
    end
  end

  // Load the output word
  always_ff @(posedge clk) begin
    if (state_r == S_SAT && out_free) begin
      out_i_r <= sat_i;
      out_q_r <= sat_q;
    end
  end

  assign out_valid = out_valid_r;
  assign out_i     = out_i_r;
  assign out_q     = out_q_r;

endmodule
